FILE: src/bitmap_id_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Bitmap ID allocator: assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define BIA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bia_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap ID allocator package
// Sizes, transaction payload types, status codes and controller states.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int POOL_BITS  = 1024;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = POOL_BITS / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int NUM_W      = $clog2(POOL_BITS) + 1;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } bia_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ALREADY = 2'd3
    } bia_status_t;

    typedef struct packed {
        bia_kind_t        kind;
        logic [NUM_W-1:0] number;
    } bia_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] number_res;
        bia_status_t      status;
        logic [NUM_W-1:0] free_count;
    } bia_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_HOLD
    } bia_state_t;

endpackage

FILE: src/bitmap_id_allocator_core.sv
// ----------------------------------------------------------------------------
// Bitmap ID allocator core
// First-fit allocator over a 1024-entry bitmap held in a 32 x 32 RAM.
//
// s_ channel: one request per transaction, allocate (lowest free entry)
// or free (1-based number). m_ channel: one response per request with the
// allocated number, a status code and the free count after the request.
// cfg channel: writes pool_size (clamped to 1024); cfg_ready is always high,
// write only while no request is in flight.
// Scan: an allocate reads bitmap words from word 0 until a clear bit in
// the pool is found or the pool ends, 1 to 32 words through the single read
// port, one word per cycle. A free reads the one word that holds its bit.
// A new request is accepted only after the previous response is registered
// and the controller is back in idle; requests do not overlap.
// Reset clears the bitmap through per-word valid bits and the in-use count,
// and sets pool_size to 1024; no clearing pass.
// A stalled m_ready: one response waits in the output register while the
// next request is accepted and processed; its result then waits in a hold
// register and no further request is taken until the output drains.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_core_macros.svh"

module bitmap_id_allocator_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bia_pkg::bia_req_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bia_pkg::bia_rsp_t          m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bia_pkg::NUM_W-1:0]  cfg_data
);
    import bia_pkg::*;

    // bitmap RAM and per-word valid bits
    logic [WORD_BITS-1:0]  mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]  vld_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_vld_reg;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  word_q;

    bia_state_t            state_reg, state_next;
    logic [WORD_IDX_W-1:0] addr_reg, addr_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [NUM_W-1:0]      in_use_reg, in_use_next;
    logic [NUM_W-1:0]      pool_size_reg;
    bia_rsp_t              res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    bia_rsp_t              m_data_reg, m_data_next;

    logic [NUM_W-1:0]      pool_eff;
    logic [NUM_W-1:0]      s_num_m1;
    logic [NUM_W-1:0]      num_m1;
    logic [NUM_W-1:0]      base;
    logic [NUM_W-1:0]      next_base;
    logic [WORD_BITS-1:0]  avail;
    logic [WORD_BITS-1:0]  lowbit;
    logic [BIT_IDX_W-1:0]  low_idx;
    logic                  out_free;
    logic                  done;
    bia_rsp_t              rsp;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign pool_eff  = (pool_size_reg > NUM_W'(POOL_BITS)) ? NUM_W'(POOL_BITS) : pool_size_reg;
    assign s_num_m1  = s_data.number - NUM_W'(1);
    assign num_m1    = num_reg - NUM_W'(1);
    assign word_q    = rd_vld_reg ? rd_data_reg : '0;
    assign base      = NUM_W'({addr_reg, {BIT_IDX_W{1'b0}}});
    assign next_base = NUM_W'({({1'b0, addr_reg} + (WORD_IDX_W+1)'(1)), {BIT_IDX_W{1'b0}}});

    // clear bits inside the pool, lowest one isolated and encoded
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            avail[j] = !word_q[j] && ((base + NUM_W'(j)) < pool_eff);
        end
        lowbit  = avail & (~avail + WORD_BITS'(1));
        low_idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lowbit[j]) begin
                low_idx = low_idx | BIT_IDX_W'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            pool_size_reg <= NUM_W'(POOL_BITS);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                pool_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        num_reg    <= num_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        num_next     = num_reg;
        in_use_next  = in_use_reg;
        res_next     = res_reg;
        rd_addr      = addr_reg;
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = word_q;
        done         = 1'b0;
        rsp          = '{number_res: '0, status: ST_OK, free_count: '0};
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    num_next = s_data.number;
                    if (s_data.kind == KIND_ALLOC) begin
                        addr_next  = '0;
                        state_next = S_SCAN;
                    end else begin
                        addr_next  = s_num_m1[BIT_IDX_W +: WORD_IDX_W];
                        state_next = S_FREE;
                    end
                    rd_addr = addr_next;
                end
            end
            S_SCAN: begin
                if (|avail) begin
                    wr_en          = 1'b1;
                    wr_data        = word_q | lowbit;
                    in_use_next    = in_use_reg + NUM_W'(1);
                    rsp.number_res = base + NUM_W'(low_idx) + NUM_W'(1);
                    rsp.status     = ST_OK;
                    done           = 1'b1;
                end else if (next_base >= pool_eff) begin
                    rsp.status = ST_FULL;
                    done       = 1'b1;
                end else begin
                    addr_next = addr_reg + WORD_IDX_W'(1);
                    rd_addr   = addr_next;
                end
            end
            S_FREE: begin
                done = 1'b1;
                if (num_reg == '0 || num_reg > pool_eff) begin
                    rsp.status = ST_RANGE;
                end else if (!word_q[num_m1[BIT_IDX_W-1:0]]) begin
                    rsp.status = ST_ALREADY;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = word_q & ~(WORD_BITS'(1) << num_m1[BIT_IDX_W-1:0]);
                    if (in_use_reg != '0) begin
                        in_use_next = in_use_reg - NUM_W'(1);
                    end
                    rsp.status = ST_OK;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (done) begin
            rsp.free_count = (pool_eff > in_use_next) ? (pool_eff - in_use_next) : '0;
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = rsp;
                state_next   = S_IDLE;
            end else begin
                res_next   = rsp;
                state_next = S_HOLD;
            end
        end
    end

    `BIA_ASSERT_NXT(a_accept_starts, s_valid && s_ready, state_reg != S_IDLE, "accepted request did not start")
    `BIA_ASSERT_NOW(a_hold_busy, state_reg == S_HOLD, m_valid_reg, "result held with output register empty")
    `BIA_ASSERT_NXT(a_alloc_count, wr_en && state_reg == S_SCAN, in_use_reg == $past(in_use_reg) + NUM_W'(1), "allocate did not bump in-use count")
    `BIA_ASSERT_NOW(a_write_state, wr_en, state_reg == S_SCAN || state_reg == S_FREE, "bitmap written outside scan or free")
    `BIA_ASSERT_NOW(a_full_zero, m_valid && m_data.status == ST_FULL, m_data.number_res == '0, "full response carries a number")

endmodule
